// ----- hw/rtl/srr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants of the selective repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

  // Default window size and sequence space.
  localparam int WINDOW_DEF    = 6;
  localparam int SEQ_SPACE_DEF = 12;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Result kinds.
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // Acknowledge number that marks a corrupted packet.
  localparam logic [6:0] ACK_NONE = 7'h7F;

  // ACK payload is twenty ASCII zero characters; their byte sum is 960.
  localparam logic [63:0] FILL64       = 64'h3030_3030_3030_3030;
  localparam logic [31:0] FILL32       = 32'h3030_3030;
  localparam logic [12:0] ACK_FILL_SUM = 13'd960;

  // One classified packet, handed from the front to the back.
  typedef struct packed {
    logic        good;
    logic [5:0]  seq;
    logic [63:0] lo;
    logic [63:0] mid;
    logic [31:0] hi;
  } srr_cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DELIVER,
    ST_ACK
  } srr_state_t;

endpackage

// ----- hw/rtl/srr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_front
// Two-stage front end: captures a packet, forms partial byte sums, then
// compares the full checksum and hands a classified command onward.
// ----------------------------------------------------------------------------
module srr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [5:0]          seq_num,
  input  logic signed [6:0]   ack_num,
  input  logic [63:0]         payload_low,
  input  logic [63:0]         payload_mid,
  input  logic [31:0]         payload_high,
  input  logic signed [31:0]  check_value,
  output srr_pkg::srr_cmd_t   cmd,
  output logic                cmd_valid,
  input  logic                cmd_stall
);
  import srr_pkg::*;

  // Sum of the eight bytes of a 64-bit word.
  function automatic logic [10:0] sum8(input logic [63:0] v);
    logic [10:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 11'(v[8*i +: 8]);
    end
    return s;
  endfunction

  // Sum of the four bytes of a 32-bit word.
  function automatic logic [9:0] sum4(input logic [31:0] v);
    logic [9:0] s;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      s = s + 10'(v[8*i +: 8]);
    end
    return s;
  endfunction

  // Capture stage.
  logic        v1;
  logic [5:0]  s1_seq;
  logic [6:0]  s1_ack;
  logic [63:0] s1_lo;
  logic [63:0] s1_mid;
  logic [31:0] s1_hi;
  logic [31:0] s1_check;

  // Partial sum stage.
  logic        v2;
  logic [5:0]  s2_seq;
  logic [63:0] s2_lo;
  logic [63:0] s2_mid;
  logic [31:0] s2_hi;
  logic [31:0] s2_check;
  logic [10:0] s2_sum_lo;
  logic [10:0] s2_sum_mid;
  logic [9:0]  s2_sum_hi;
  logic [7:0]  s2_hdr;

  logic        adv2;
  logic        load1;
  logic [13:0] total;

  // Stage two drains when empty or when the queue takes its beat.
  assign adv2      = !v2 || !cmd_stall;
  assign in_stall  = v1 && !adv2;
  assign load1     = in_valid && !in_stall;
  assign cmd_valid = v2;

  // Valid flags of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (load1) begin
        v1 <= 1'b1;
      end else if (adv2) begin
        v1 <= 1'b0;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk) begin
    if (load1) begin
      s1_seq   <= seq_num;
      s1_ack   <= ack_num;
      s1_lo    <= payload_low;
      s1_mid   <= payload_mid;
      s1_hi    <= payload_high;
      s1_check <= check_value;
    end
    if (adv2 && v1) begin
      s2_seq     <= s1_seq;
      s2_lo      <= s1_lo;
      s2_mid     <= s1_mid;
      s2_hi      <= s1_hi;
      s2_check   <= s1_check;
      s2_sum_lo  <= sum8(s1_lo);
      s2_sum_mid <= sum8(s1_mid);
      s2_sum_hi  <= sum4(s1_hi);
      s2_hdr     <= {2'b00, s1_seq} + {s1_ack[6], s1_ack};
    end
  end

  // Final checksum and classification.
  assign total = {3'b000, s2_sum_lo} + {3'b000, s2_sum_mid} + {4'b0000, s2_sum_hi}
               + {{6{s2_hdr[7]}}, s2_hdr};

  always_comb begin
    cmd.good = (s2_check == {{18{total[13]}}, total});
    cmd.seq  = s2_seq;
    cmd.lo   = s2_lo;
    cmd.mid  = s2_mid;
    cmd.hi   = s2_hi;
  end

endmodule

// ----- hw/rtl/srr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module srr_queue (
  input  logic              clk,
  input  logic              rst,
  input  srr_pkg::srr_cmd_t wr_data,
  input  logic              wr_valid,
  output logic              wr_stall,
  output srr_pkg::srr_cmd_t rd_data,
  output logic              rd_valid,
  input  logic              rd_stall
);
  import srr_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  srr_cmd_t     mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_stall = (count == CW'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;
  assign rd_data  = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- hw/rtl/srr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_back
// Back end: buffers good packets in the window, delivers held payloads in
// order from the window base, then issues the ACK beat.
// ----------------------------------------------------------------------------
module srr_back #(
  parameter int WINDOW    = srr_pkg::WINDOW_DEF,
  parameter int SEQ_SPACE = srr_pkg::SEQ_SPACE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  srr_pkg::srr_cmd_t cmd,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              kind,
  output logic              out_seq,
  output logic signed [6:0] out_ack,
  output logic [12:0]       out_check,
  output logic [63:0]       out_payload_low,
  output logic [63:0]       out_payload_mid,
  output logic [31:0]       out_payload_high,
  output logic              last
);
  import srr_pkg::*;

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int BW = $clog2(SEQ_SPACE);
  localparam int DW = $clog2(WINDOW + 1);
  localparam int U  = WINDOW % SEQ_SPACE;

  srr_state_t     state;
  srr_state_t     state_next;
  logic [SEQ_SPACE-1:0] held;
  logic [BW-1:0]  base;
  logic           ack_bit;
  logic [DW-1:0]  dcnt;
  logic           cur_good;
  logic [5:0]     cur_seq;

  logic [63:0]    st_lo  [WINDOW];
  logic [63:0]    st_mid [WINDOW];
  logic [31:0]    st_hi  [WINDOW];

  logic [SW-1:0]  slot_tab [SEQ_SPACE];
  logic [BW-1:0]  seq_idx;
  logic [BW:0]    win_off_w;
  logic [BW-1:0]  win_off;
  logic           seq_ok;
  logic           in_win;
  logic           write_en;
  logic           out_load;
  logic           pop;
  logic           dlv;
  logic           ack_go;
  logic           ack_seq;
  logic [6:0]     ack_val;

  // Slot of each sequence number in the payload store.
  for (genvar g = 0; g < SEQ_SPACE; g++) begin : g_slot
    assign slot_tab[g] = SW'(g % WINDOW);
  end

  // Window test: distance from the base, modulo the sequence space.
  assign seq_idx   = cmd.seq[BW-1:0];
  assign seq_ok    = ({1'b0, cmd.seq} < 7'(SEQ_SPACE));
  assign win_off_w = (seq_idx >= base) ? {1'b0, seq_idx} - {1'b0, base}
                                       : {1'b0, seq_idx} + (BW+1)'(SEQ_SPACE) - {1'b0, base};
  assign win_off   = win_off_w[BW-1:0];
  assign in_win    = seq_ok && ((U == 0) || (win_off < BW'(U)));

  assign out_load  = !out_valid || !out_stall;
  assign cmd_stall = (state != ST_IDLE);
  assign write_en  = pop && cmd.good && in_win && !held[seq_idx];

  // Sequencer: next state and per-cycle actions.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    dlv        = 1'b0;
    ack_go     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          pop        = 1'b1;
          state_next = cmd.good ? ST_DELIVER : ST_ACK;
        end
      end
      ST_DELIVER: begin
        if (out_load) begin
          if ((dcnt < DW'(WINDOW)) && held[base]) begin
            dlv = 1'b1;
          end else begin
            state_next = ST_ACK;
          end
        end
      end
      ST_ACK: begin
        if (out_load) begin
          ack_go     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ACK contents.
  assign ack_seq = cur_good ? !ack_bit : ack_bit;
  assign ack_val = cur_good ? {1'b0, cur_seq} : ACK_NONE;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      held      <= '0;
      base      <= '0;
      ack_bit   <= 1'b1;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        dcnt <= '0;
      end else if (dlv) begin
        dcnt <= dcnt + 1'b1;
      end
      if (write_en) begin
        held[seq_idx] <= 1'b1;
      end
      if (dlv) begin
        held[base] <= 1'b0;
        base       <= (base == BW'(SEQ_SPACE - 1)) ? '0 : base + 1'b1;
      end
      if (ack_go && !cur_good) begin
        ack_bit <= !ack_bit;
      end
      if (out_load) begin
        out_valid <= dlv || ack_go;
      end
    end
  end

  // Current command and payload store.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_good <= cmd.good;
      cur_seq  <= cmd.seq;
    end
    if (write_en) begin
      st_lo[slot_tab[seq_idx]]  <= cmd.lo;
      st_mid[slot_tab[seq_idx]] <= cmd.mid;
      st_hi[slot_tab[seq_idx]]  <= cmd.hi;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (dlv) begin
      kind             <= KIND_DELIVER;
      out_seq          <= 1'b0;
      out_ack          <= '0;
      out_check        <= '0;
      out_payload_low  <= st_lo[slot_tab[base]];
      out_payload_mid  <= st_mid[slot_tab[base]];
      out_payload_high <= st_hi[slot_tab[base]];
      last             <= 1'b0;
    end else if (ack_go) begin
      kind             <= KIND_ACK;
      out_seq          <= ack_seq;
      out_ack          <= ack_val;
      out_check        <= ACK_FILL_SUM + {12'b0, ack_seq} + {{6{ack_val[6]}}, ack_val};
      out_payload_low  <= FILL64;
      out_payload_mid  <= FILL64;
      out_payload_high <= FILL32;
      last             <= 1'b1;
    end
  end

endmodule

// ----- hw/rtl/selective_repeat_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receiver
// Selective repeat receiver: checks, buffers and delivers data packets.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one data packet per beat.
// The output channel (out_valid / out_stall) carries the results of each
// packet: zero to WINDOW delivery beats (kind 0) in sequence order, then one
// ACK beat (kind 1) with last set. A corrupted packet yields only the ACK.
// The front end captures and checks a packet in its capture and partial sum
// stages, the queue stores the command, and the back end takes and buffers
// it before loading the first result into its output register; a good
// packet that releases no delivery passes through ST_DELIVER first.
// The back end sequencer sets the packet rate: it takes a new command only
// in ST_IDLE, once a good packet's deliveries and ACK or a corrupted
// packet's ACK are issued. A two-entry command queue lets the front end keep
// taking packets while the back end is busy.
// Reset clears all held flags, sets the window base to zero and the ACK bit
// to one; buffered payloads are not cleared.
// While out_stall is high the output beat holds and the back end waits; the
// queue fills and in_stall then rises.
// ----------------------------------------------------------------------------
module selective_repeat_receiver #(
  parameter int WINDOW    = srr_pkg::WINDOW_DEF,
  parameter int SEQ_SPACE = srr_pkg::SEQ_SPACE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         seq_num,
  input  logic signed [6:0]  ack_num,
  input  logic [63:0]        payload_low,
  input  logic [63:0]        payload_mid,
  input  logic [31:0]        payload_high,
  input  logic signed [31:0] check_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic               out_seq,
  output logic signed [6:0]  out_ack,
  output logic [12:0]        out_check,
  output logic [63:0]        out_payload_low,
  output logic [63:0]        out_payload_mid,
  output logic [31:0]        out_payload_high,
  output logic               last
);
  import srr_pkg::*;

  srr_cmd_t cmd_f;
  srr_cmd_t cmd_q;
  logic     cmd_f_valid;
  logic     cmd_f_stall;
  logic     cmd_q_valid;
  logic     cmd_q_stall;

  // Capture and checksum.
  srr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .seq_num      (seq_num),
    .ack_num      (ack_num),
    .payload_low  (payload_low),
    .payload_mid  (payload_mid),
    .payload_high (payload_high),
    .check_value  (check_value),
    .cmd          (cmd_f),
    .cmd_valid    (cmd_f_valid),
    .cmd_stall    (cmd_f_stall)
  );

  // Command queue.
  srr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (cmd_f),
    .wr_valid (cmd_f_valid),
    .wr_stall (cmd_f_stall),
    .rd_data  (cmd_q),
    .rd_valid (cmd_q_valid),
    .rd_stall (cmd_q_stall)
  );

  // Buffering, delivery and ACK.
  srr_back #(
    .WINDOW    (WINDOW),
    .SEQ_SPACE (SEQ_SPACE)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd_q),
    .cmd_valid        (cmd_q_valid),
    .cmd_stall        (cmd_q_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .out_seq          (out_seq),
    .out_ack          (out_ack),
    .out_check        (out_check),
    .out_payload_low  (out_payload_low),
    .out_payload_mid  (out_payload_mid),
    .out_payload_high (out_payload_high),
    .last             (last)
  );

  // Only the ACK closes a packet's results.
  a_last_is_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == kind))
    else $error("last and kind disagree");

  // Delivery beats carry no ACK header.
  a_deliver_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_DELIVER) |->
      (out_seq == 1'b0) && (out_ack == 7'sd0) && (out_check == 13'd0))
    else $error("delivery beat has ACK header bits");

  // ACK checksum matches its header.
  a_ack_check: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_ACK) |->
      (out_check == ACK_FILL_SUM + {12'b0, out_seq} + {{6{out_ack[6]}}, out_ack}))
    else $error("ACK checksum mismatch");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
